[rtl/tcse_pkg.sv]
// ============================================================================
// tcse_pkg
// Shared types and constants for the telnet COM-port stream engine: telnet
// byte codes, command codes, and the reply descriptor passed front to back.
// ============================================================================
package tcse_pkg;

    // Telnet protocol bytes.
    localparam logic [7:0] BYTE_IAC  = 8'd255;
    localparam logic [7:0] BYTE_DONT = 8'd254;
    localparam logic [7:0] BYTE_DO   = 8'd253;
    localparam logic [7:0] BYTE_WONT = 8'd252;
    localparam logic [7:0] BYTE_WILL = 8'd251;
    localparam logic [7:0] BYTE_SB   = 8'd250;
    localparam logic [7:0] BYTE_SE   = 8'd240;

    // Options and COM-port subcommands.
    localparam logic [7:0] OPTION_BIN      = 8'd0;
    localparam logic [7:0] OPT_SGA         = 8'd3;
    localparam logic [7:0] OPTION_COM_PORT = 8'd44;
    localparam logic [7:0] CPC_SET_BAUD    = 8'd1;
    localparam logic [7:0] CPC_SET_CTRL    = 8'd5;
    localparam logic [7:0] CPC_REPLY       = 8'd100;
    localparam logic [7:0] CTRL_DTR_ON     = 8'd8;
    localparam logic [7:0] CTRL_DTR_OFF    = 8'd9;
    localparam logic [7:0] CTRL_RTS_ON     = 8'd11;
    localparam logic [7:0] CTRL_RTS_OFF    = 8'd12;

    // Input commands.
    localparam logic [1:0] CMD_CLIENT  = 2'd0;
    localparam logic [1:0] CMD_TARGET  = 2'd1;
    localparam logic [1:0] CMD_CONNECT = 2'd2;

    // Result destinations.
    localparam logic DEST_UART   = 1'b0;
    localparam logic DEST_CLIENT = 1'b1;

    // Baud restored at reset until the register is written.
    localparam logic [31:0] BAUD_RESET = 32'd115200;

    // Subnegotiation storage: the count saturates at SUB_DEPTH, and only the
    // leading SUB_KEEP bytes are ever interpreted.
    localparam int SUB_DEPTH = 24;
    localparam int SUB_KEEP  = 6;
    localparam int SUB_CNT_W = $clog2(SUB_DEPTH + 1);

    // Reply descriptor queue.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Longest burst is the connect offer of 15 bytes.
    localparam int BURST_IDX_W = 4;

    typedef enum logic [2:0] {
        KIND_SINGLE,
        KIND_FF_PAIR,
        KIND_NEG,
        KIND_BAUD,
        KIND_CTRL,
        KIND_CONNECT
    } kind_t;

    // One descriptor expands into a burst of result bytes in the back end.
    typedef struct packed {
        kind_t       kind;
        logic        dest;
        logic [7:0]  b0;        // data byte, or verb byte of a negotiation reply
        logic [7:0]  opt;       // option byte of a negotiation reply
        logic [31:0] data;      // echoed subnegotiation bytes, first in [31:24]
        logic [31:0] baud;      // baud after this input
        logic        boot_low;
        logic        en_low;
    } desc_t;

    // Number of result bytes a descriptor expands to.
    function automatic logic [BURST_IDX_W-1:0] burst_len(input kind_t kind);
        logic [BURST_IDX_W-1:0] len;
        unique case (kind)
            KIND_SINGLE:  len = BURST_IDX_W'(1);
            KIND_FF_PAIR: len = BURST_IDX_W'(2);
            KIND_NEG:     len = BURST_IDX_W'(3);
            KIND_BAUD:    len = BURST_IDX_W'(10);
            KIND_CTRL:    len = BURST_IDX_W'(7);
            KIND_CONNECT: len = BURST_IDX_W'(15);
            default:      len = BURST_IDX_W'(1);
        endcase
        return len;
    endfunction

endpackage

[rtl/tcse_front.sv]
// ============================================================================
// tcse_front
// Front end: accepts input items, runs the telnet parser and option
// negotiation, applies COM-port commands, and pushes one reply descriptor
// per item that produces any output.
// ============================================================================
module tcse_front import tcse_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [7:0]  data_byte,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        queue_full,
    output logic        push,
    output desc_t       push_desc
);

    typedef enum logic [2:0] {
        PH_DATA,
        PH_IAC,
        PH_OPT,
        PH_SB,
        PH_SBIAC
    } phase_t;

    localparam logic [1:0] VERB_WILL = 2'd0;
    localparam logic [1:0] VERB_WONT = 2'd1;
    localparam logic [1:0] VERB_DO   = 2'd2;
    localparam logic [1:0] VERB_DONT = 2'd3;

    localparam logic [SUB_CNT_W-1:0] SUB_FULL = SUB_CNT_W'(SUB_DEPTH);

    phase_t                phase_reg, phase_next;
    logic [1:0]            verb_reg, verb_next;
    logic [SUB_CNT_W-1:0]  sub_count_reg, sub_count_next;
    logic [7:0]            sub_data_reg [SUB_KEEP];
    logic [7:0]            sub_data_next [SUB_KEEP];
    logic [2:0]            local_reg, local_next;
    logic [2:0]            remote_reg, remote_next;
    logic                  dtr_reg, dtr_next;
    logic                  rts_reg, rts_next;
    logic [31:0]           baud_reg, baud_next;
    logic [31:0]           default_baud_reg;

    logic                  accept;
    logic [2:0]            opt_mask;
    logic [7:0]            verb_diff;
    logic [31:0]           sub_baud;
    logic                  sub_push;
    logic [7:0]            sub_push_byte;

    // Bit of a supported option in the enable masks, zero if unsupported.
    function automatic logic [2:0] opt_bit(input logic [7:0] opt);
        logic [2:0] m;
        case (opt)
            OPTION_BIN:      m = 3'b001;
            OPT_SGA:         m = 3'b010;
            OPTION_COM_PORT: m = 3'b100;
            default:         m = 3'b000;
        endcase
        return m;
    endfunction

    assign in_ready  = !queue_full;
    assign accept    = in_valid && !queue_full;
    assign opt_mask  = opt_bit(data_byte);
    assign verb_diff = data_byte - BYTE_WILL;
    assign sub_baud  = {sub_data_reg[2], sub_data_reg[3], sub_data_reg[4], sub_data_reg[5]};

    // Parser, negotiation and session update for one accepted item.
    always_comb
    begin
        phase_next     = phase_reg;
        verb_next      = verb_reg;
        sub_count_next = sub_count_reg;
        local_next     = local_reg;
        remote_next    = remote_reg;
        dtr_next       = dtr_reg;
        rts_next       = rts_reg;
        baud_next      = baud_reg;
        sub_push       = 1'b0;
        sub_push_byte  = data_byte;
        push           = 1'b0;
        push_desc      = '0;
        push_desc.kind = KIND_SINGLE;
        push_desc.dest = DEST_CLIENT;

        if (accept)
        begin
            case (command)
                CMD_CLIENT:
                begin
                    unique case (phase_reg)
                        PH_DATA:
                        begin
                            if (data_byte == BYTE_IAC)
                            begin
                                phase_next = PH_IAC;
                            end
                            else
                            begin
                                push           = 1'b1;
                                push_desc.dest = DEST_UART;
                                push_desc.b0   = data_byte;
                            end
                        end
                        PH_IAC:
                        begin
                            phase_next = PH_DATA;
                            if (data_byte == BYTE_IAC)
                            begin
                                push           = 1'b1;
                                push_desc.dest = DEST_UART;
                                push_desc.b0   = BYTE_IAC;
                            end
                            else if (data_byte == BYTE_SB)
                            begin
                                sub_count_next = '0;
                                phase_next     = PH_SB;
                            end
                            else if (data_byte >= BYTE_WILL && data_byte <= BYTE_DONT)
                            begin
                                verb_next  = verb_diff[1:0];
                                phase_next = PH_OPT;
                            end
                        end
                        PH_OPT:
                        begin
                            phase_next     = PH_DATA;
                            push_desc.kind = KIND_NEG;
                            push_desc.opt  = data_byte;
                            unique case (verb_reg)
                                VERB_DO:
                                begin
                                    if (opt_mask == 3'b000)
                                    begin
                                        push         = 1'b1;
                                        push_desc.b0 = BYTE_WONT;
                                    end
                                    else if ((local_reg & opt_mask) == 3'b000)
                                    begin
                                        push         = 1'b1;
                                        push_desc.b0 = BYTE_WILL;
                                        local_next   = local_reg | opt_mask;
                                    end
                                end
                                VERB_DONT:
                                begin
                                    if ((local_reg & opt_mask) != 3'b000)
                                    begin
                                        push         = 1'b1;
                                        push_desc.b0 = BYTE_WONT;
                                        local_next   = local_reg & ~opt_mask;
                                    end
                                end
                                VERB_WILL:
                                begin
                                    if (opt_mask == 3'b000)
                                    begin
                                        push         = 1'b1;
                                        push_desc.b0 = BYTE_DONT;
                                    end
                                    else if ((remote_reg & opt_mask) == 3'b000)
                                    begin
                                        push         = 1'b1;
                                        push_desc.b0 = BYTE_DO;
                                        remote_next  = remote_reg | opt_mask;
                                    end
                                end
                                VERB_WONT:
                                begin
                                    if ((remote_reg & opt_mask) != 3'b000)
                                    begin
                                        push         = 1'b1;
                                        push_desc.b0 = BYTE_DONT;
                                        remote_next  = remote_reg & ~opt_mask;
                                    end
                                end
                                default:
                                begin
                                    push = 1'b0;
                                end
                            endcase
                        end
                        PH_SB:
                        begin
                            if (data_byte == BYTE_IAC)
                            begin
                                phase_next = PH_SBIAC;
                            end
                            else
                            begin
                                sub_push = 1'b1;
                            end
                        end
                        PH_SBIAC:
                        begin
                            phase_next = PH_SB;
                            if (data_byte == BYTE_SE)
                            begin
                                phase_next = PH_DATA;
                                // Apply a complete COM-port command and echo it.
                                if (sub_count_reg >= SUB_CNT_W'(2)
                                        && sub_data_reg[0] == OPTION_COM_PORT)
                                begin
                                    if (sub_data_reg[1] == CPC_SET_BAUD
                                            && sub_count_reg >= SUB_CNT_W'(6))
                                    begin
                                        if (sub_baud != 32'd0)
                                        begin
                                            baud_next = sub_baud;
                                        end
                                        push           = 1'b1;
                                        push_desc.kind = KIND_BAUD;
                                        push_desc.data = sub_baud;
                                    end
                                    else if (sub_data_reg[1] == CPC_SET_CTRL
                                            && sub_count_reg >= SUB_CNT_W'(3))
                                    begin
                                        case (sub_data_reg[2])
                                            CTRL_DTR_ON:  dtr_next = 1'b1;
                                            CTRL_DTR_OFF: dtr_next = 1'b0;
                                            CTRL_RTS_ON:  rts_next = 1'b1;
                                            CTRL_RTS_OFF: rts_next = 1'b0;
                                            default:      dtr_next = dtr_reg;
                                        endcase
                                        push           = 1'b1;
                                        push_desc.kind = KIND_CTRL;
                                        push_desc.data = {sub_data_reg[2], 24'd0};
                                    end
                                end
                            end
                            else if (data_byte == BYTE_IAC)
                            begin
                                sub_push = 1'b1;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_DATA;
                        end
                    endcase
                end
                CMD_TARGET:
                begin
                    push         = 1'b1;
                    push_desc.b0 = data_byte;
                    if (data_byte == BYTE_IAC)
                    begin
                        push_desc.kind = KIND_FF_PAIR;
                    end
                end
                CMD_CONNECT:
                begin
                    phase_next     = PH_DATA;
                    verb_next      = VERB_WILL;
                    sub_count_next = '0;
                    local_next     = 3'b011;
                    remote_next    = 3'b111;
                    dtr_next       = 1'b0;
                    rts_next       = 1'b0;
                    baud_next      = default_baud_reg;
                    push           = 1'b1;
                    push_desc.kind = KIND_CONNECT;
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end

        if (sub_push && sub_count_reg < SUB_FULL)
        begin
            sub_count_next = sub_count_reg + SUB_CNT_W'(1);
        end

        // State seen by every result of this item.
        push_desc.baud     = baud_next;
        push_desc.boot_low = dtr_next && !rts_next;
        push_desc.en_low   = rts_next && !dtr_next;
    end

    // Capture of the leading subnegotiation bytes.
    always_comb
    begin
        for (int i = 0; i < SUB_KEEP; i++)
        begin
            sub_data_next[i] = sub_data_reg[i];
            if (sub_push && sub_count_reg == SUB_CNT_W'(i))
            begin
                sub_data_next[i] = sub_push_byte;
            end
        end
    end

    // Session state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_DATA;
            verb_reg         <= VERB_WILL;
            sub_count_reg    <= '0;
            local_reg        <= '0;
            remote_reg       <= '0;
            dtr_reg          <= 1'b0;
            rts_reg          <= 1'b0;
            baud_reg         <= BAUD_RESET;
            default_baud_reg <= BAUD_RESET;
        end
        else
        begin
            phase_reg     <= phase_next;
            verb_reg      <= verb_next;
            sub_count_reg <= sub_count_next;
            local_reg     <= local_next;
            remote_reg    <= remote_next;
            dtr_reg       <= dtr_next;
            rts_reg       <= rts_next;
            baud_reg      <= baud_next;
            if (cfg_wr_en)
            begin
                default_baud_reg <= cfg_wr_data;
            end
        end
    end

    // Subnegotiation bytes carry no reset.
    always_ff @(posedge clk)
    begin
        sub_data_reg <= sub_data_next;
    end

endmodule

[rtl/tcse_queue.sv]
// ============================================================================
// tcse_queue
// Short descriptor queue between the front end and the back end. A push and
// a pop may happen in the same cycle.
// ============================================================================
module tcse_queue import tcse_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  desc_t push_desc,
    output logic  full,
    input  logic  pop,
    output desc_t head,
    output logic  empty
);

    desc_t                  mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;

    assign full  = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + QUEUE_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + QUEUE_PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + QUEUE_CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - QUEUE_CNT_W'(1);
            end
        end
    end

    // Descriptor storage.
    always_ff @(posedge clk)
    begin
        if (push) begin
            mem[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

[rtl/tcse_back.sv]
// ============================================================================
// tcse_back
// Back end: expands the descriptor at the queue head into its burst of
// result bytes, one per cycle while out_ready does not stall it, into the output register.
// ============================================================================
module tcse_back import tcse_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  desc_t       head,
    input  logic        empty,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        dest,
    output logic [7:0]  out_byte,
    output logic        last,
    output logic [31:0] baud_rate,
    output logic        boot_pin_low,
    output logic        enable_pin_low
);

    logic [BURST_IDX_W-1:0] idx_reg;
    logic                   out_valid_reg;
    logic                   dest_reg;
    logic [7:0]             byte_reg;
    logic                   last_reg;
    logic [31:0]            baud_reg;
    logic                   boot_low_reg;
    logic                   en_low_reg;

    logic                   load;
    logic                   is_last;
    logic [7:0]             byte_sel;

    // Offer sent on connect.
    function automatic logic [7:0] connect_byte(input logic [BURST_IDX_W-1:0] i);
        logic [7:0] b;
        case (i)
            4'd0, 4'd3, 4'd6, 4'd9, 4'd12: b = BYTE_IAC;
            4'd1, 4'd7:                    b = BYTE_WILL;
            4'd4, 4'd10, 4'd13:            b = BYTE_DO;
            4'd2, 4'd5:                    b = OPTION_BIN;
            4'd8, 4'd11:                   b = OPT_SGA;
            default:                       b = OPTION_COM_PORT;
        endcase
        return b;
    endfunction

    // Framing shared by both COM-port echoes.
    function automatic logic [7:0] echo_head(input logic [BURST_IDX_W-1:0] i,
                                             input logic [7:0] code);
        logic [7:0] b;
        case (i)
            4'd0:    b = BYTE_IAC;
            4'd1:    b = BYTE_SB;
            4'd2:    b = OPTION_COM_PORT;
            default: b = code + CPC_REPLY;
        endcase
        return b;
    endfunction

    assign load    = !empty && (!out_valid_reg || out_ready);
    assign is_last = (idx_reg == burst_len(head.kind) - BURST_IDX_W'(1));
    assign pop     = load && is_last;

    // Byte at the current position of the burst.
    always_comb
    begin
        unique case (head.kind)
            KIND_SINGLE:  byte_sel = head.b0;
            KIND_FF_PAIR: byte_sel = BYTE_IAC;
            KIND_NEG:
            begin
                case (idx_reg)
                    4'd0:    byte_sel = BYTE_IAC;
                    4'd1:    byte_sel = head.b0;
                    default: byte_sel = head.opt;
                endcase
            end
            KIND_BAUD:
            begin
                case (idx_reg)
                    4'd4:    byte_sel = head.data[31:24];
                    4'd5:    byte_sel = head.data[23:16];
                    4'd6:    byte_sel = head.data[15:8];
                    4'd7:    byte_sel = head.data[7:0];
                    4'd8:    byte_sel = BYTE_IAC;
                    4'd9:    byte_sel = BYTE_SE;
                    default: byte_sel = echo_head(idx_reg, CPC_SET_BAUD);
                endcase
            end
            KIND_CTRL:
            begin
                case (idx_reg)
                    4'd4:    byte_sel = head.data[31:24];
                    4'd5:    byte_sel = BYTE_IAC;
                    4'd6:    byte_sel = BYTE_SE;
                    default: byte_sel = echo_head(idx_reg, CPC_SET_CTRL);
                endcase
            end
            KIND_CONNECT: byte_sel = connect_byte(idx_reg);
            default:      byte_sel = head.b0;
        endcase
    end

    // Burst position and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                idx_reg       <= is_last ? '0 : idx_reg + BURST_IDX_W'(1);
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            dest_reg     <= head.dest;
            byte_reg     <= byte_sel;
            last_reg     <= is_last;
            baud_reg     <= head.baud;
            boot_low_reg <= head.boot_low;
            en_low_reg   <= head.en_low;
        end
    end

    assign out_valid      = out_valid_reg;
    assign dest           = dest_reg;
    assign out_byte       = byte_reg;
    assign last           = last_reg;
    assign baud_rate      = baud_reg;
    assign boot_pin_low   = boot_low_reg;
    assign enable_pin_low = en_low_reg;

endmodule

[rtl/telnet_comport_stream_engine.sv]
// ============================================================================
// telnet_comport_stream_engine
// Telnet COM-port server core: parses client bytes, negotiates options,
// applies COM-port baud and control commands, escapes target UART bytes and
// answers a client connect with the option offer.
// ============================================================================
//
//   Channel | Handshake                  | Payload
//   --------+----------------------------+---------------------------------
//   input   | in_valid / in_ready        | command, data_byte
//   result  | out_valid / out_ready      | dest, out_byte, last, baud_rate,
//           |                            | boot_pin_low, enable_pin_low
//   config  | cfg_wr_en (no wait)        | cfg_wr_data (default baud)
//
// An item is taken every cycle while the four-entry descriptor queue has
// room; its results come from the output register after the descriptor
// passes the queue. The back end sends one result byte per cycle unless
// out_ready stalls it; a reply is at most 15 bytes (the connect offer).
// in_ready falls only when the queue is full; results wait in the output
// register under out_ready low. Reset needs no clearing pass.
//
module telnet_comport_stream_engine import tcse_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        dest,
    output logic [7:0]  out_byte,
    output logic        last,
    output logic [31:0] baud_rate,
    output logic        boot_pin_low,
    output logic        enable_pin_low,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data
);

    logic  push;
    desc_t push_desc;
    logic  queue_full;
    logic  pop;
    desc_t head;
    logic  empty;

    // Parser and session state.
    tcse_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .data_byte   (data_byte),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .queue_full  (queue_full),
        .push        (push),
        .push_desc   (push_desc)
    );

    // Reply descriptors waiting for the back end.
    tcse_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .full      (queue_full),
        .pop       (pop),
        .head      (head),
        .empty     (empty)
    );

    // Burst expansion and output register.
    tcse_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .empty          (empty),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .dest           (dest),
        .out_byte       (out_byte),
        .last           (last),
        .baud_rate      (baud_rate),
        .boot_pin_low   (boot_pin_low),
        .enable_pin_low (enable_pin_low)
    );

endmodule

[rtl/tcse_checker.sv]
// ============================================================================
// tcse_checker
// Port-level checks for the telnet COM-port stream engine.
// ============================================================================
module tcse_checker import tcse_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        dest,
    input logic [7:0]  out_byte,
    input logic        last,
    input logic [31:0] baud_rate,
    input logic        boot_pin_low,
    input logic        enable_pin_low
);

    // A stalled result holds its byte.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last))
        else $error("result changed while stalled");

    // Bytes toward the UART are always single-result transfers.
    a_uart_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && dest == DEST_UART |-> last)
        else $error("UART byte not marked last");

    // A burst continues without a gap once its first byte is taken.
    a_burst_gapless: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=> out_valid)
        else $error("gap inside a reply burst");

    // Baud and pin state are the same across one burst.
    a_burst_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=>
            $stable(baud_rate) && $stable(boot_pin_low) && $stable(enable_pin_low))
        else $error("state changed inside a reply burst");

    // The auto-reset truth table never pulls both pins low.
    a_pins_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(boot_pin_low && enable_pin_low))
        else $error("boot and enable pins both low");

endmodule

bind telnet_comport_stream_engine tcse_checker u_checker (.*);
